/* rtl/rtbc_pkg.sv */
// ----------------------------------------------------------------------------
// rtbc_pkg - shared constants and helpers for the residue-to-binary converter
// Widths, the modulus M = 2^93 - 2^31 and the term operation codes.
// ----------------------------------------------------------------------------
package rtbc_pkg;

    localparam int RES_W     = 32;
    localparam int ACC_W     = 128;
    localparam int VAL_W     = 93;
    localparam int LOW_W     = 64;
    localparam int HIGH_W    = VAL_W - LOW_W;
    localparam int TOP_SHIFT = 35;
    localparam int N_RED     = TOP_SHIFT + 1;
    localparam int S_DATA_W  = 3 * RES_W;
    localparam int M_DATA_W  = ((VAL_W + 7) / 8) * 8;

    // M = 2^93 - 2^31: high part 0x1fffffff, low part 0xffffffff80000000
    localparam logic [VAL_W-1:0] MOD_M = {29'h1fff_ffff, 64'hffff_ffff_8000_0000};

    typedef enum logic [1:0] {
        TERM_ZERO = 2'd0,
        TERM_ADD  = 2'd1,
        TERM_SUB  = 2'd2
    } term_op_t;

    // Residue as a signed contribution to the wrapping accumulator
    function automatic logic [ACC_W-1:0] term_val(input term_op_t op,
                                                 input logic [RES_W-1:0] x);
        logic [ACC_W-1:0] ext;
        ext = {{(ACC_W-RES_W){1'b0}}, x};
        case (op)
            TERM_ADD: term_val = ext;
            TERM_SUB: term_val = ~ext + {{(ACC_W-1){1'b0}}, 1'b1};
            default:  term_val = '0;
        endcase
    endfunction

endpackage

/* rtl/rtbc_build_cell.sv */
// ----------------------------------------------------------------------------
// rtbc_build_cell - one round of the reconstruction sum
// Adds or subtracts each residue its op selects, shifts left, and hands the word onward.
// ----------------------------------------------------------------------------
module rtbc_build_cell
    import rtbc_pkg::*;
#(
    parameter term_op_t OP_A  = TERM_ZERO,
    parameter term_op_t OP_B  = TERM_ZERO,
    parameter term_op_t OP_C  = TERM_ZERO,
    parameter int       SHIFT = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [ACC_W-1:0] up_acc,
    input  logic [RES_W-1:0] up_a,
    input  logic [RES_W-1:0] up_b,
    input  logic [RES_W-1:0] up_c,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic [ACC_W-1:0] dn_acc,
    output logic [RES_W-1:0] dn_a,
    output logic [RES_W-1:0] dn_b,
    output logic [RES_W-1:0] dn_c
);

    logic             valid_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [RES_W-1:0] a_reg, b_reg, c_reg;
    logic [ACC_W-1:0] sum;
    logic             advance;

    assign advance  = !valid_reg || dn_ready;
    assign up_ready = advance;

    always_comb begin
        sum      = up_acc + term_val(OP_A, up_a) + term_val(OP_B, up_b)
                 + term_val(OP_C, up_c);
        acc_next = sum << SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= up_valid;
        end
    end

    // advance payload only with a word
    always_ff @(posedge aclk) begin
        if (advance && up_valid) begin
            acc_reg <= acc_next;
            a_reg   <= up_a;
            b_reg   <= up_b;
            c_reg   <= up_c;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_acc   = acc_reg;
    assign dn_a     = a_reg;
    assign dn_b     = b_reg;
    assign dn_c     = c_reg;

endmodule

/* rtl/rtbc_reduce_cell.sv */
// ----------------------------------------------------------------------------
// rtbc_reduce_cell - one restoring step of the reduction modulo M
// Subtracts M shifted left by SHIFT when the word is not smaller.
// ----------------------------------------------------------------------------
module rtbc_reduce_cell
    import rtbc_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [ACC_W-1:0] up_acc,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic [ACC_W-1:0] dn_acc
);

    localparam logic [ACC_W-1:0] MOD_SH = {{(ACC_W-VAL_W){1'b0}}, MOD_M} << SHIFT;

    logic             valid_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W:0]   diff;
    logic             advance;

    assign advance  = !valid_reg || dn_ready;
    assign up_ready = advance;

    // borrow out of the top bit means the word is below the shifted modulus
    always_comb begin
        diff     = {1'b0, up_acc} - {1'b0, MOD_SH};
        acc_next = diff[ACC_W] ? up_acc : diff[ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && up_valid) begin
            acc_reg <= acc_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_acc   = acc_reg;

endmodule

/* rtl/rns_to_binary_converter.sv */
// ----------------------------------------------------------------------------
// rns_to_binary_converter - residue triple to binary integer
// Chinese remainder reconstruction for moduli 2^31-1, 2^31 and 2^31+1.
// ----------------------------------------------------------------------------
// Each input word carries residues modulo 2^31-1, 2^31 and 2^31+1; each output
// word carries the unique integer in 0 to 2^93-2^31-1 congruent to all three.
// Residues at or above their modulus are accepted and taken by congruence.
// The block takes one word per cycle while the output side is not stalled and
// returns one word per input, in order. The datapath is the row of cells:
// five build cells form the reconstruction sum with shifts by 30, 1, 30,
// 31 and 0, then 36 reduce cells each compare with M shifted left by 35
// down to 0 and subtract when not smaller. Every cell holds one word; a
// cell takes a new word whenever it is empty or its neighbor takes its
// word, so bubbles close up while the output is stalled and input keeps
// flowing until the row is full. The last reduce cell is the output
// register. s_tready follows m_tready combinationally through the row.
// ----------------------------------------------------------------------------
module rns_to_binary_converter
    import rtbc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // res_a [31:0], res_b [63:32], res_c [95:64]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // value_low [63:0], value_high [92:64], zero
);

    localparam int N_BUILD = 5;

    localparam term_op_t OPS_A [N_BUILD] = '{TERM_ADD, TERM_ZERO, TERM_ADD, TERM_ZERO,
                                              TERM_ZERO};
    localparam term_op_t OPS_B [N_BUILD] = '{TERM_ZERO, TERM_SUB, TERM_ZERO, TERM_SUB,
                                              TERM_ADD};
    localparam term_op_t OPS_C [N_BUILD] = '{TERM_ADD, TERM_ADD, TERM_SUB, TERM_SUB,
                                              TERM_ZERO};
    localparam int       SHIFTS [N_BUILD] = '{30, 1, 30, 31, 0};

    // Links of the build row
    logic             b_valid [N_BUILD+1];
    logic             b_ready [N_BUILD+1];
    logic [ACC_W-1:0] b_acc   [N_BUILD+1];
    logic [RES_W-1:0] b_a     [N_BUILD+1];
    logic [RES_W-1:0] b_b     [N_BUILD+1];
    logic [RES_W-1:0] b_c     [N_BUILD+1];

    // Links of the reduce row
    logic             r_valid [N_RED+1];
    logic             r_ready [N_RED+1];
    logic [ACC_W-1:0] r_acc   [N_RED+1];

    // Unpack input word; seed the sum with 2*res_b
    assign b_valid[0] = s_tvalid;
    assign s_tready   = b_ready[0];
    assign b_a[0]     = s_tdata[RES_W-1:0];
    assign b_b[0]     = s_tdata[2*RES_W-1:RES_W];
    assign b_c[0]     = s_tdata[3*RES_W-1:2*RES_W];
    assign b_acc[0]   = {{(ACC_W-RES_W-1){1'b0}}, b_b[0], 1'b0};

    genvar g;
    generate
        for (g = 0; g < N_BUILD; g++) begin : g_build
            rtbc_build_cell #(
                .OP_A  (OPS_A[g]),
                .OP_B  (OPS_B[g]),
                .OP_C  (OPS_C[g]),
                .SHIFT (SHIFTS[g])
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .up_valid (b_valid[g]),
                .up_ready (b_ready[g]),
                .up_acc   (b_acc[g]),
                .up_a     (b_a[g]),
                .up_b     (b_b[g]),
                .up_c     (b_c[g]),
                .dn_valid (b_valid[g+1]),
                .dn_ready (b_ready[g+1]),
                .dn_acc   (b_acc[g+1]),
                .dn_a     (b_a[g+1]),
                .dn_b     (b_b[g+1]),
                .dn_c     (b_c[g+1])
            );
        end
    endgenerate

    // Hand the finished sum to the reduce row
    assign r_valid[0]       = b_valid[N_BUILD];
    assign b_ready[N_BUILD] = r_ready[0];
    assign r_acc[0]         = b_acc[N_BUILD];

    generate
        for (g = 0; g < N_RED; g++) begin : g_reduce
            rtbc_reduce_cell #(
                .SHIFT (TOP_SHIFT - g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .up_valid (r_valid[g]),
                .up_ready (r_ready[g]),
                .up_acc   (r_acc[g]),
                .dn_valid (r_valid[g+1]),
                .dn_ready (r_ready[g+1]),
                .dn_acc   (r_acc[g+1])
            );
        end
    endgenerate

    // Output register is the last reduce cell
    assign m_tvalid       = r_valid[N_RED];
    assign r_ready[N_RED] = m_tready;
    assign m_tdata        = {{(M_DATA_W-VAL_W){1'b0}}, r_acc[N_RED][VAL_W-1:0]};

endmodule

/* rtl/rtbc_checker.sv */
// ----------------------------------------------------------------------------
// rtbc_checker - port-level checks for the residue-to-binary converter
// Output handshake, flow of ready through the row, reset and result range.
// ----------------------------------------------------------------------------
module rtbc_checker
    import rtbc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // A taking output side leaves every cell free to advance
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side takes words");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Result below M: pad bits zero and bits 92..31 not all ones
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:VAL_W] == '0) && !(&m_tdata[VAL_W-1:31]))
        else $error("result not reduced below the modulus");

endmodule

bind rns_to_binary_converter rtbc_checker u_rtbc_checker (.*);

/* tb/tb_rns_to_binary_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rns_to_binary_converter - stream test of the residue-to-binary converter
// Sends residue triples on the input stream. A CRT model with the datapath's own
// sum and reduction gives each word's expected value; every output word is checked in order.
// ----------------------------------------------------------------------------
module tb_rns_to_binary_converter;
    import rtbc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RANDOM_WORDS = 2000;
    localparam int BLOCK_WORDS  = 100;     // sender redraws its idle mode this often
    localparam int RX_BLOCK     = 256;     // receiver redraws its idle mode this often
    localparam int MAX_IDLE     = 11;
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, well past the row depth
    localparam int DRAIN_CYCLES = 60;      // watch for stray words after the last expected word
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    typedef logic [RES_W-1:0]    residue_t;
    typedef logic [VAL_W-1:0]    value_t;
    typedef logic [S_DATA_W-1:0] triple_t;

    // Moduli of the three residue channels, and M = 2^93 - 2^31
    localparam residue_t MOD_A = 32'h7fff_ffff;
    localparam residue_t MOD_B = 32'h8000_0000;
    localparam residue_t MOD_C = 32'h8000_0001;
    localparam value_t   CRT_MODULUS = {29'h1fff_ffff, 64'hffff_ffff_8000_0000};

    // Directed triples, packed as {res_c, res_b, res_a}
    localparam triple_t CORNERS [21] = '{
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0000},   // zero
        {32'h0000_0001, 32'h0000_0001, 32'h0000_0001},   // one
        {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},   // all fields at max
        {32'h8000_0000, 32'h7fff_ffff, 32'h7fff_fffe},   // M-1: largest value
        {32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff},   // each residue equal to its modulus
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0001},
        {32'h0000_0000, 32'h0000_0001, 32'h0000_0000},
        {32'h0000_0001, 32'h0000_0000, 32'h0000_0000},
        {32'h0000_0000, 32'h0000_0000, 32'h7fff_fffe},
        {32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000},
        {32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
        {32'h0000_0000, 32'h0000_0000, 32'hffff_ffff},
        {32'h0000_0000, 32'hffff_ffff, 32'h0000_0000},
        {32'hffff_ffff, 32'h0000_0000, 32'h0000_0000},
        {32'h0000_0000, 32'h0000_0000, 32'h8000_0000},   // non-canonical first residue
        {32'h8000_0002, 32'h8000_0001, 32'h8000_0000},   // all just above modulus
        {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555},
        {32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa},
        {32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff},
        {32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000},
        {32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff}
    };

    // ------------------------------------------------------------------------
    // Scoreboard: rebuild the integer from each accepted triple, queue it, and
    // compare every output word with the oldest queued value.
    // ------------------------------------------------------------------------
    class crt_scoreboard;
        value_t expected_q[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Build the CRT sum in a 128-bit wrapping accumulator, then reduce it
        // with restoring steps against M shifted left 35 down to 0.
        function value_t crt_rebuild(input residue_t a, input residue_t b,
                                     input residue_t c);
            logic [ACC_W-1:0] acc;
            logic [ACC_W-1:0] ax;
            logic [ACC_W-1:0] bx;
            logic [ACC_W-1:0] cx;
            logic [ACC_W-1:0] m_shifted;
            ax  = ACC_W'(a);
            bx  = ACC_W'(b);
            cx  = ACC_W'(c);
            acc = bx << 1;
            acc = (acc + ax + cx) << 30;
            acc = (acc - bx + cx) << 1;
            acc = (acc + ax - cx) << 30;
            acc = (acc - bx - cx) << 31;
            acc = acc + bx;
            for (int k = TOP_SHIFT; k >= 0; k--) begin
                m_shifted = ACC_W'(CRT_MODULUS) << k;
                if (acc >= m_shifted) begin
                    acc = acc - m_shifted;
                end
            end
            return acc[VAL_W-1:0];
        endfunction

        function void note_triple(input residue_t a, input residue_t b,
                                  input residue_t c);
            expected_q.push_back(crt_rebuild(a, b, c));
        endfunction

        function void flag(input string what, input logic [63:0] want,
                           input logic [63:0] got);
            if (mismatches < REPORT_MAX) begin
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
            end
            mismatches++;
        endfunction

        function void check_word(input logic [M_DATA_W-1:0] data);
            value_t want;
            if (expected_q.size() == 0) begin
                flag("unexpected word", 64'd0, data[LOW_W-1:0]);
                return;
            end
            want = expected_q.pop_front();
            if (data[LOW_W-1:0] !== want[LOW_W-1:0]) begin
                flag("value_low", want[LOW_W-1:0], data[LOW_W-1:0]);
            end
            if (data[VAL_W-1:LOW_W] !== want[VAL_W-1:LOW_W]) begin
                flag("value_high", 64'(want[VAL_W-1:LOW_W]), 64'(data[VAL_W-1:LOW_W]));
            end
            if (data[M_DATA_W-1:VAL_W] !== '0) begin
                flag("padding", 64'd0, 64'(data[M_DATA_W-1:VAL_W]));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;  // res_a [31:0], res_b [63:32], res_c [95:64]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // value_low [63:0], value_high [92:64], zero

    always #CLK_HALF aclk = ~aclk;

    rns_to_binary_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    crt_scoreboard sb = new();

    int   words_sent = 0;
    bit   tx_idle    = 1'b1;   // sender inserts random gaps while set, outside a hold-off
    logic rx_hold    = 1'b0;   // long receiver hold-off, owned by the pressure process

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Draw a residue: half full 32-bit random, one in eight below the modulus, with extra weight near zero,
    // around the channel modulus and at the top of the 32-bit range.
    function automatic residue_t pick_residue(input residue_t modulus);
        case ($urandom_range(0, 7))
            0:       return residue_t'($urandom_range(0, 3));
            1:       return modulus + residue_t'($urandom_range(0, 6)) - residue_t'(3);
            2:       return 32'hffff_ffff - residue_t'($urandom_range(0, 3));
            3:       return residue_t'($urandom_range(modulus - 1, 0));
            default: return residue_t'($urandom);
        endcase
    endfunction

    // Offer one word after an optional gap; hold it until the block takes it.
    // Keep tvalid high across back-to-back words so it is never toggled in
    // one step. Skip gaps during a hold-off so the pipeline fills and stalls.
    task automatic send_triple(input residue_t a, input residue_t b, input residue_t c);
        int gap;
        gap = (tx_idle && !rx_hold) ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_triple(a, b, c);
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: after each accepted word, drop tready for a random number of
    // cycles (none in quiet stretches), and hold it low for a hold-off.
    // ------------------------------------------------------------------------
    int rx_wait  = 0;
    int rx_count = 0;
    bit rx_idle  = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata);
                rx_count++;
                if (rx_count % RX_BLOCK == 0) begin
                    rx_idle = ($urandom_range(0, 2) != 0);
                end
                rx_wait = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Pressure: twice during the random phase, stall the output for a long
    // stretch while the sender keeps offering words back to back.
    initial begin
        int marks [2];
        marks = '{500, 1400};
        foreach (marks[i]) begin
            wait (words_sent >= marks[i]);
            @(posedge aclk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
    end

    // Watchdog: a hung handshake or a lost word ends the run here
    int cycles = 0;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed corners, random words, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (CORNERS[i]) begin
            send_triple(CORNERS[i][31:0], CORNERS[i][63:32], CORNERS[i][95:64]);
        end

        // Alternate stretches with and without sender gaps
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % BLOCK_WORDS == 0) begin
                tx_idle = ($urandom_range(0, 2) != 0);
            end
            send_triple(pick_residue(MOD_A), pick_residue(MOD_B), pick_residue(MOD_C));
        end
        s_tvalid <= 1'b0;

        // Wait for every queued value, then watch a while for stray words
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rtbc_pkg.sv
rtl/rtbc_build_cell.sv
rtl/rtbc_reduce_cell.sv
rtl/rns_to_binary_converter.sv
rtl/rtbc_checker.sv
tb/tb_rns_to_binary_converter.sv
